// File: rtl/tonp_pkg.sv
`default_nettype none

package tonp_pkg;

  // Telnet command codes.
  localparam logic [7:0] IAC      = 8'hFF;
  localparam logic [7:0] CMD_DONT = 8'hFE;
  localparam logic [7:0] CMD_DO   = 8'hFD;
  localparam logic [7:0] CMD_WONT = 8'hFC;
  localparam logic [7:0] CMD_WILL = 8'hFB;
  localparam logic [7:0] CMD_SB   = 8'hFA;
  localparam logic [7:0] CMD_SE   = 8'hF0;

  // Telnet option codes.
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] TT_IS      = 8'd0;
  localparam logic [7:0] TT_SEND    = 8'd1;

  // UTF-8 byte order mark and the C1 control range.
  localparam logic [7:0] BOM_0   = 8'hEF;
  localparam logic [7:0] BOM_1   = 8'hBB;
  localparam logic [7:0] BOM_2   = 8'hBF;
  localparam logic [7:0] C1_LO   = 8'h80;
  localparam logic [7:0] C1_HI   = 8'h9F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Window size limits and reset values.
  localparam logic [7:0] WIN_MAX       = 8'hFE;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd24;

  // Result destinations.
  localparam logic DEST_DISPLAY = 1'b0;
  localparam logic DEST_NETWORK = 1'b1;

  // Configuration register indexes.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Protocol parser states.
  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_IAC    = 3'd1,
    ST_CMD    = 3'd2,
    ST_SB_OPT = 3'd3,
    ST_SB     = 3'd4,
    ST_SB_IAC = 3'd5
  } state_t;

  // Kinds of output sequence one input byte can cause.
  typedef enum logic [2:0] {
    JOB_DATA   = 3'd0,
    JOB_SPACES = 3'd1,
    JOB_REPLY3 = 3'd2,
    JOB_NAWS   = 3'd3,
    JOB_TTYPE  = 3'd4
  } job_kind_t;

  // One output sequence. For a data job, cmd carries the data byte.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] cmd;
    logic [7:0] opt;
  } job_t;

  // Emitter status seen by the top level.
  typedef struct packed {
    logic busy;
    logic take_ok;
  } emit_status_t;

  // Number of bytes in a sequence.
  function automatic logic [3:0] job_len(input job_kind_t kind);
    logic [3:0] len;
    case (kind)
      JOB_DATA:   len = 4'd1;
      JOB_SPACES: len = 4'd3;
      JOB_REPLY3: len = 4'd3;
      JOB_NAWS:   len = 4'd12;
      JOB_TTYPE:  len = 4'd10;
      default:    len = 4'd1;
    endcase
    return len;
  endfunction

  // A window value of 255 would need an IAC escape, so it is sent as 254.
  function automatic logic [7:0] clamp_win(input logic [7:0] v);
    return (v == IAC) ? WIN_MAX : v;
  endfunction

  // Byte at position idx of a sequence.
  function automatic logic [7:0] job_byte(input job_t job, input logic [3:0] idx,
                                          input logic [7:0] cols,
                                          input logic [7:0] rows);
    logic [7:0] b;
    case (job.kind)
      JOB_DATA:   b = job.cmd;
      JOB_SPACES: b = CH_SPACE;
      JOB_REPLY3: begin
        case (idx)
          4'd0:    b = IAC;
          4'd1:    b = job.cmd;
          default: b = job.opt;
        endcase
      end
      JOB_NAWS: begin
        case (idx)
          4'd0:    b = IAC;
          4'd1:    b = CMD_WILL;
          4'd2:    b = OPT_NAWS;
          4'd3:    b = IAC;
          4'd4:    b = CMD_SB;
          4'd5:    b = OPT_NAWS;
          4'd6:    b = 8'h00;
          4'd7:    b = clamp_win(cols);
          4'd8:    b = 8'h00;
          4'd9:    b = clamp_win(rows);
          4'd10:   b = IAC;
          default: b = CMD_SE;
        endcase
      end
      JOB_TTYPE: begin
        case (idx)
          4'd0:    b = IAC;
          4'd1:    b = CMD_SB;
          4'd2:    b = OPT_TTYPE;
          4'd3:    b = TT_IS;
          4'd4:    b = 8'h41;
          4'd5:    b = 8'h4E;
          4'd6:    b = 8'h53;
          4'd7:    b = 8'h49;
          4'd8:    b = IAC;
          default: b = CMD_SE;
        endcase
      end
      default: b = job.cmd;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/telnet_option_negotiator_top.sv
// Telnet option negotiator, receive side.
// Received bytes enter on the s_* stream, one byte per transfer in s_tdata.
// Results leave on the m_* stream: m_tdata is the byte, m_tuser is the
// destination (0 display, 1 network reply) and m_tlast marks the final
// result caused by one input byte. Bytes that cause no result are absorbed.
// An input transfer is first registered as a job, and its first result is
// then loaded into the output register. Plain data flows at one byte per
// cycle while the receiver does not stall. A reply of 3, 10 or 12 bytes
// leaves the output sequencer at one byte per cycle while the receiver does
// not stall, and s_tready stays low until its last byte is being handed to
// the output register. When the receiver stalls, the output register holds
// its result. Input bytes are still taken while the sequencer holds no job;
// after one that causes a result, s_tready stays low until the output drains.
// The APB port sets window_columns (address 0) and window_rows (address 4)
// for the NAWS report; write them only while the block is idle.
// Synchronous reset clears the parser to normal data, empties the output
// and restores 80 columns by 24 rows.
`default_nettype none

module telnet_option_negotiator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte[7:0]
  output logic             m_tuser,   // destination
  output logic             m_tlast,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                   accept;
  logic                   job_valid;
  tonp_pkg::job_t         job;
  tonp_pkg::emit_status_t status;
  logic [7:0]             window_columns;
  logic [7:0]             window_rows;
  logic                   cfg_write;

  assign s_tready = status.take_ok;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {24'd0, (paddr[2] == tonp_pkg::REG_ROWS) ? window_rows : window_columns};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= tonp_pkg::COLUMNS_RESET;
      window_rows    <= tonp_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == tonp_pkg::REG_ROWS) begin
        window_rows <= pwdata[7:0];
      end else begin
        window_columns <= pwdata[7:0];
      end
    end
  end

  tonp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .rx_byte   (s_tdata),
    .job       (job),
    .job_valid (job_valid)
  );

  tonp_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .take     (accept && job_valid),
    .job_in   (job),
    .cols     (window_columns),
    .rows     (window_rows),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .status   (status)
  );

`ifndef SYNTH
  // With no sequence pending, the input must never be throttled.
  assert property (@(posedge clk) disable iff (rst) !status.busy |-> s_tready)
    else $error("input stalled while the output sequencer is idle");

  // Only the BOM replacement emits display bytes that are not last.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tonp_pkg::DEST_DISPLAY && !m_tlast) |-> m_tdata == tonp_pkg::CH_SPACE)
    else $error("unexpected multi-byte display sequence");

  // Reset leaves the output empty.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A new sequence may only start when the previous one is finishing.
  assert property (@(posedge clk) disable iff (rst)
    (accept && job_valid && status.busy) |-> (m_tready || !m_tvalid))
    else $error("sequence started while the previous one is still stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/tonp_parser.sv
`default_nettype none

module tonp_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  output tonp_pkg::job_t     job,
  output logic               job_valid
);

  tonp_pkg::state_t state, state_next;
  logic [7:0] pending_command, pending_command_next;
  logic [7:0] sub_option, sub_option_next;
  logic       sub_first_byte, sub_first_byte_next;
  logic       type_requested, type_requested_next;
  logic [1:0] bom_progress, bom_progress_next;

  logic is_c1;
  logic sub_ttype_first;

  always_comb begin
    is_c1 = (rx_byte >= tonp_pkg::C1_LO) && (rx_byte <= tonp_pkg::C1_HI);
    sub_ttype_first = (sub_option == tonp_pkg::OPT_TTYPE) && sub_first_byte;
  end

  // Next-state logic of the telnet command parser and the BOM matcher.
  always_comb begin
    state_next           = state;
    pending_command_next = pending_command;
    sub_option_next      = sub_option;
    sub_first_byte_next  = sub_first_byte;
    type_requested_next  = type_requested;
    bom_progress_next    = bom_progress;
    unique case (state)
      tonp_pkg::ST_IAC: begin
        if (rx_byte == tonp_pkg::CMD_WILL || rx_byte == tonp_pkg::CMD_WONT ||
            rx_byte == tonp_pkg::CMD_DO || rx_byte == tonp_pkg::CMD_DONT) begin
          pending_command_next = rx_byte;
          state_next = tonp_pkg::ST_CMD;
        end else if (rx_byte == tonp_pkg::CMD_SB) begin
          state_next = tonp_pkg::ST_SB_OPT;
        end else begin
          state_next = tonp_pkg::ST_NORMAL;
        end
      end
      tonp_pkg::ST_CMD: begin
        state_next = tonp_pkg::ST_NORMAL;
      end
      tonp_pkg::ST_SB_OPT: begin
        sub_option_next     = rx_byte;
        sub_first_byte_next = 1'b1;
        type_requested_next = 1'b0;
        state_next          = tonp_pkg::ST_SB;
      end
      tonp_pkg::ST_SB: begin
        if (rx_byte == tonp_pkg::IAC) begin
          state_next = tonp_pkg::ST_SB_IAC;
        end else if (sub_ttype_first) begin
          sub_first_byte_next = 1'b0;
          if (rx_byte == tonp_pkg::TT_SEND) begin
            type_requested_next = 1'b1;
          end
        end
      end
      tonp_pkg::ST_SB_IAC: begin
        if (rx_byte == tonp_pkg::CMD_SE) begin
          state_next          = tonp_pkg::ST_NORMAL;
          type_requested_next = 1'b0;
        end else begin
          // A doubled IAC counts as one data byte 0xFF, which is never SEND.
          if (rx_byte == tonp_pkg::IAC && sub_ttype_first) begin
            sub_first_byte_next = 1'b0;
          end
          state_next = tonp_pkg::ST_SB;
        end
      end
      default: begin
        state_next = tonp_pkg::ST_NORMAL;
        if (rx_byte == tonp_pkg::IAC) begin
          state_next = tonp_pkg::ST_IAC;
        end else if (bom_progress == 2'd0) begin
          if (rx_byte == tonp_pkg::BOM_0) begin
            bom_progress_next = 2'd1;
          end
        end else if (bom_progress == 2'd1) begin
          bom_progress_next = (rx_byte == tonp_pkg::BOM_1) ? 2'd2 : 2'd0;
        end else begin
          bom_progress_next = 2'd0;
        end
      end
    endcase
  end

  // Output sequence caused by the byte at the input.
  always_comb begin
    job.kind  = tonp_pkg::JOB_DATA;
    job.cmd   = rx_byte;
    job.opt   = rx_byte;
    job_valid = 1'b0;
    unique case (state)
      tonp_pkg::ST_IAC: begin
        // Doubled IAC goes to the display and bypasses both filters.
        job_valid = (rx_byte == tonp_pkg::IAC);
      end
      tonp_pkg::ST_CMD: begin
        if (pending_command == tonp_pkg::CMD_WILL) begin
          job_valid = 1'b1;
          job.kind  = tonp_pkg::JOB_REPLY3;
          if (rx_byte == tonp_pkg::OPT_ECHO || rx_byte == tonp_pkg::OPT_SGA ||
              rx_byte == tonp_pkg::OPT_BINARY) begin
            job.cmd = tonp_pkg::CMD_DO;
          end else begin
            job.cmd = tonp_pkg::CMD_DONT;
          end
        end else if (pending_command == tonp_pkg::CMD_DO) begin
          job_valid = 1'b1;
          job.kind  = tonp_pkg::JOB_REPLY3;
          if (rx_byte == tonp_pkg::OPT_TTYPE || rx_byte == tonp_pkg::OPT_SGA ||
              rx_byte == tonp_pkg::OPT_BINARY) begin
            job.cmd = tonp_pkg::CMD_WILL;
          end else if (rx_byte == tonp_pkg::OPT_NAWS) begin
            job.kind = tonp_pkg::JOB_NAWS;
            job.cmd  = tonp_pkg::CMD_WILL;
          end else begin
            job.cmd = tonp_pkg::CMD_WONT;
          end
        end
      end
      tonp_pkg::ST_SB_OPT: begin
        job_valid = 1'b0;
      end
      tonp_pkg::ST_SB: begin
        job_valid = 1'b0;
      end
      tonp_pkg::ST_SB_IAC: begin
        if (rx_byte == tonp_pkg::CMD_SE && type_requested) begin
          job_valid = 1'b1;
          job.kind  = tonp_pkg::JOB_TTYPE;
        end
      end
      default: begin
        if (rx_byte != tonp_pkg::IAC) begin
          if (bom_progress == 2'd0) begin
            job_valid = (rx_byte != tonp_pkg::BOM_0) && !is_c1;
          end else if (bom_progress == 2'd1) begin
            job_valid = (rx_byte != tonp_pkg::BOM_1) && !is_c1;
          end else if (rx_byte == tonp_pkg::BOM_2) begin
            job_valid = 1'b1;
            job.kind  = tonp_pkg::JOB_SPACES;
          end else begin
            job_valid = !is_c1;
          end
        end
      end
    endcase
  end

  // Parser state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tonp_pkg::ST_NORMAL;
      pending_command <= 8'h00;
      sub_option      <= 8'h00;
      sub_first_byte  <= 1'b0;
      type_requested  <= 1'b0;
      bom_progress    <= 2'd0;
    end else if (take) begin
      state           <= state_next;
      pending_command <= pending_command_next;
      sub_option      <= sub_option_next;
      sub_first_byte  <= sub_first_byte_next;
      type_requested  <= type_requested_next;
      bom_progress    <= bom_progress_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tonp_emitter.sv
`default_nettype none

module tonp_emitter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire tonp_pkg::job_t     job_in,
  input  wire logic [7:0]         cols,
  input  wire logic [7:0]         rows,
  input  wire logic               m_tready,
  output logic                    m_tvalid,
  output logic [7:0]              m_tdata,   // out_byte[7:0]
  output logic                    m_tuser,   // destination
  output logic                    m_tlast,
  output tonp_pkg::emit_status_t  status
);

  logic            busy;
  tonp_pkg::job_t  job;
  logic [3:0]      idx;
  logic            advance;
  logic            is_last;

  // The output register can load when it is empty or being drained.
  always_comb begin
    advance        = !m_tvalid || m_tready;
    is_last        = (idx == (tonp_pkg::job_len(job.kind) - 4'd1));
    status.busy    = busy;
    status.take_ok = !busy || (advance && is_last);
  end

  // Sequence control: one byte of the current job per output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= busy;
      end
      if (take) begin
        busy <= 1'b1;
        idx  <= 4'd0;
      end else if (advance && busy) begin
        idx <= idx + 4'd1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_in;
    end
    if (advance && busy) begin
      m_tdata <= tonp_pkg::job_byte(job, idx, cols, rows);
      m_tuser <= (job.kind == tonp_pkg::JOB_DATA || job.kind == tonp_pkg::JOB_SPACES) ?
                 tonp_pkg::DEST_DISPLAY : tonp_pkg::DEST_NETWORK;
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
  import tonp_pkg::*;

  // One result byte as it leaves the block.
  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } out_item_t;

  // One row of the directed stimulus. When typed is set, the result is read
  // off the row: nothing, or a single display byte.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       has_out;
    logic [7:0] out_byte;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 26;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte[7:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte[7:0]
  logic        m_tuser;   // destination
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: parser, subnegotiation tracking, BOM match and window size.
  state_t     parse_st;
  logic [7:0] held_cmd;
  logic [7:0] sb_opt;
  logic       sb_first;
  logic       tt_send;
  logic [1:0] bom_cnt;
  logic [7:0] cols_cfg;
  logic [7:0] rows_cfg;

  out_item_t  step_out[$];
  out_item_t  pending_out_bytes[$];
  logic [7:0] rx_plan[$];

  int  mismatches = 0;
  int  src_gap = 0;
  int  sink_stall = 0;
  bit  gaps_on = 1'b0;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{8'h00,     1'b1, 1'b1, 8'h00},  // lowest data byte passes
    '{C1_LO,     1'b1, 1'b0, 8'h00},  // C1 range is dropped
    '{C1_HI,     1'b1, 1'b0, 8'h00},
    '{BOM_0,     1'b1, 1'b0, 8'h00},  // full byte order mark
    '{BOM_1,     1'b1, 1'b0, 8'h00},
    '{BOM_2,     1'b0, 1'b0, 8'h00},
    '{BOM_0,     1'b1, 1'b0, 8'h00},  // broken byte order mark
    '{8'h41,     1'b1, 1'b1, 8'h41},
    '{IAC,       1'b1, 1'b0, 8'h00},  // doubled IAC is data 0xFF
    '{IAC,       1'b1, 1'b1, 8'hFF},
    '{IAC,       1'b1, 1'b0, 8'h00},  // WILL ECHO
    '{CMD_WILL,  1'b1, 1'b0, 8'h00},
    '{OPT_ECHO,  1'b0, 1'b0, 8'h00},
    '{IAC,       1'b1, 1'b0, 8'h00},  // DO NAWS with the reset window size
    '{CMD_DO,    1'b1, 1'b0, 8'h00},
    '{OPT_NAWS,  1'b0, 1'b0, 8'h00},
    '{IAC,       1'b1, 1'b0, 8'h00},  // TTYPE SEND with a stray IAC inside
    '{CMD_SB,    1'b1, 1'b0, 8'h00},
    '{OPT_TTYPE, 1'b1, 1'b0, 8'h00},
    '{TT_SEND,   1'b1, 1'b0, 8'h00},
    '{IAC,       1'b1, 1'b0, 8'h00},
    '{8'h00,     1'b1, 1'b0, 8'h00},
    '{IAC,       1'b1, 1'b0, 8'h00},
    '{CMD_SE,    1'b0, 1'b0, 8'h00},
    '{IAC,       1'b1, 1'b0, 8'h00},  // unknown command is dropped
    '{8'hF1,     1'b1, 1'b0, 8'h00}
  };

  telnet_option_negotiator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("** telnet_option_negotiator_top: FAILED **");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic emit(input logic dest, input logic [7:0] b);
    step_out.push_back('{dest, b, 1'b0});
  endtask

  task automatic reply3(input logic [7:0] cmd, input logic [7:0] opt);
    emit(DEST_NETWORK, IAC);
    emit(DEST_NETWORK, cmd);
    emit(DEST_NETWORK, opt);
  endtask

  // A window size of 255 would need escaping, so it is reported as 254.
  function automatic logic [7:0] window_byte(input logic [7:0] v);
    return (v == 8'hFF) ? WIN_MAX : v;
  endfunction

  // Answer to WILL or DO; WONT and DONT are never answered.
  task automatic answer_request(input logic [7:0] cmd, input logic [7:0] opt);
    if (cmd == CMD_WILL) begin
      if (opt == OPT_ECHO || opt == OPT_SGA || opt == OPT_BINARY) reply3(CMD_DO, opt);
      else reply3(CMD_DONT, opt);
    end else if (cmd == CMD_DO) begin
      if (opt == OPT_TTYPE || opt == OPT_SGA || opt == OPT_BINARY) begin
        reply3(CMD_WILL, opt);
      end else if (opt == OPT_NAWS) begin
        reply3(CMD_WILL, opt);
        emit(DEST_NETWORK, IAC);
        emit(DEST_NETWORK, CMD_SB);
        emit(DEST_NETWORK, OPT_NAWS);
        emit(DEST_NETWORK, 8'h00);
        emit(DEST_NETWORK, window_byte(cols_cfg));
        emit(DEST_NETWORK, 8'h00);
        emit(DEST_NETWORK, window_byte(rows_cfg));
        emit(DEST_NETWORK, IAC);
        emit(DEST_NETWORK, CMD_SE);
      end else begin
        reply3(CMD_WONT, opt);
      end
    end
  endtask

  // Only the first data byte of a TTYPE subnegotiation matters.
  task automatic sb_data_byte(input logic [7:0] c);
    if (sb_opt == OPT_TTYPE && sb_first) begin
      sb_first = 1'b0;
      if (c == TT_SEND) tt_send = 1'b1;
    end
  endtask

  // Byte order mark replacement, then the C1 filter.
  task automatic display_filter(input logic [7:0] c);
    if (bom_cnt == 2'd0) begin
      if (c == BOM_0) begin
        bom_cnt = 2'd1;
        return;
      end
    end else if (bom_cnt == 2'd1) begin
      if (c == BOM_1) begin
        bom_cnt = 2'd2;
        return;
      end
      bom_cnt = 2'd0;
    end else begin
      bom_cnt = 2'd0;
      if (c == BOM_2) begin
        emit(DEST_DISPLAY, CH_SPACE);
        emit(DEST_DISPLAY, CH_SPACE);
        emit(DEST_DISPLAY, CH_SPACE);
        return;
      end
    end
    if (c >= C1_LO && c <= C1_HI) return;
    emit(DEST_DISPLAY, c);
  endtask

  // Predicts the results of one accepted input byte into step_out.
  task automatic negotiate_byte(input logic [7:0] c);
    step_out.delete();
    case (parse_st)
      ST_IAC: begin
        if (c == IAC) begin
          parse_st = ST_NORMAL;
          emit(DEST_DISPLAY, IAC);
        end else if (c == CMD_WILL || c == CMD_WONT || c == CMD_DO || c == CMD_DONT) begin
          held_cmd = c;
          parse_st = ST_CMD;
        end else if (c == CMD_SB) begin
          parse_st = ST_SB_OPT;
        end else begin
          parse_st = ST_NORMAL;
        end
      end
      ST_CMD: begin
        answer_request(held_cmd, c);
        parse_st = ST_NORMAL;
      end
      ST_SB_OPT: begin
        sb_opt = c;
        sb_first = 1'b1;
        tt_send = 1'b0;
        parse_st = ST_SB;
      end
      ST_SB: begin
        if (c == IAC) parse_st = ST_SB_IAC;
        else sb_data_byte(c);
      end
      ST_SB_IAC: begin
        if (c == CMD_SE) begin
          parse_st = ST_NORMAL;
          if (tt_send) begin
            tt_send = 1'b0;
            emit(DEST_NETWORK, IAC);
            emit(DEST_NETWORK, CMD_SB);
            emit(DEST_NETWORK, OPT_TTYPE);
            emit(DEST_NETWORK, TT_IS);
            emit(DEST_NETWORK, 8'h41);
            emit(DEST_NETWORK, 8'h4E);
            emit(DEST_NETWORK, 8'h53);
            emit(DEST_NETWORK, 8'h49);
            emit(DEST_NETWORK, IAC);
            emit(DEST_NETWORK, CMD_SE);
          end
        end else begin
          if (c == IAC) sb_data_byte(IAC);
          parse_st = ST_SB;
        end
      end
      default: begin
        parse_st = ST_NORMAL;
        if (c == IAC) parse_st = ST_IAC;
        else display_filter(c);
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endtask

  // Drives one input transfer, with a random gap first, and queues what it
  // should cause. Starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic typed, input logic has_out,
                           input logic [7:0] out_byte);
    if (gaps_on && src_gap == 0 && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 16);
    while (src_gap > 0) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      src_gap--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    negotiate_byte(b);
    if (typed) begin
      if (has_out) pending_out_bytes.push_back('{DEST_DISPLAY, out_byte, 1'b1});
    end else begin
      foreach (step_out[i]) pending_out_bytes.push_back(step_out[i]);
    end
    @(negedge clk);
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic wait_drained();
    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write over the configuration port: setup, then access.
  task automatic write_window(input logic idx, input logic [7:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_COLUMNS) cols_cfg = v;
    else rows_cfg = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_option();
    logic [7:0] opt;
    case ($urandom_range(0, 6))
      0:       opt = OPT_BINARY;
      1:       opt = OPT_ECHO;
      2:       opt = OPT_SGA;
      3:       opt = OPT_TTYPE;
      4, 5:    opt = OPT_NAWS;
      default: opt = 8'($urandom_range(0, 255));
    endcase
    return opt;
  endfunction

  // Appends one telnet sequence to the plan: mostly well formed with random
  // content, sometimes broken or pure noise.
  task automatic plan_sequence();
    int         kind;
    int         count;
    logic [7:0] cmd;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      count = $urandom_range(1, 6);
      repeat (count) begin
        if ($urandom_range(0, 3) == 0) rx_plan.push_back(8'($urandom_range(C1_LO, C1_HI)));
        else rx_plan.push_back(8'($urandom_range(0, 254)));
      end
    end else if (kind < 38) begin
      rx_plan.push_back(BOM_0);
      if ($urandom_range(0, 3) == 0) begin
        rx_plan.push_back(8'($urandom_range(0, 254)));
      end else begin
        rx_plan.push_back(BOM_1);
        if ($urandom_range(0, 3) == 0) rx_plan.push_back(8'($urandom_range(0, 254)));
        else rx_plan.push_back(BOM_2);
      end
    end else if (kind < 45) begin
      rx_plan.push_back(IAC);
      rx_plan.push_back(IAC);
    end else if (kind < 70) begin
      case ($urandom_range(0, 4))
        0:       cmd = CMD_WILL;
        1:       cmd = CMD_WONT;
        2:       cmd = CMD_DONT;
        default: cmd = CMD_DO;
      endcase
      rx_plan.push_back(IAC);
      rx_plan.push_back(cmd);
      rx_plan.push_back(pick_option());
    end else if (kind < 85) begin
      rx_plan.push_back(IAC);
      rx_plan.push_back(CMD_SB);
      rx_plan.push_back(($urandom_range(0, 9) < 6) ? OPT_TTYPE : pick_option());
      case ($urandom_range(0, 4))
        0:       rx_plan.push_back(TT_IS);
        1:       rx_plan.push_back(8'($urandom_range(0, 254)));
        default: rx_plan.push_back(TT_SEND);
      endcase
      count = $urandom_range(0, 4);
      repeat (count) begin
        case ($urandom_range(0, 5))
          0: begin
            rx_plan.push_back(IAC);
            rx_plan.push_back(IAC);
          end
          1: begin
            // IAC followed by something other than SE stays inside.
            rx_plan.push_back(IAC);
            rx_plan.push_back(8'($urandom_range(0, 8'hEF)));
          end
          default: rx_plan.push_back(8'($urandom_range(0, 254)));
        endcase
      end
      rx_plan.push_back(IAC);
      rx_plan.push_back(CMD_SE);
    end else if (kind < 90) begin
      // Command codes below SB are not handled and are dropped.
      rx_plan.push_back(IAC);
      rx_plan.push_back(8'($urandom_range(0, 8'hF9)));
    end else begin
      count = $urandom_range(1, 4);
      repeat (count) rx_plan.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Random phase: a NAWS request to show the current window size, then
  // random sequences.
  task automatic run_random(input int n);
    rx_plan.delete();
    rx_plan.push_back(IAC);
    rx_plan.push_back(CMD_DO);
    rx_plan.push_back(OPT_NAWS);
    while (rx_plan.size() < n) plan_sequence();
    foreach (rx_plan[i]) send_byte(rx_plan[i], 1'b0, 1'b0, 8'h00);
    s_tvalid <= 1'b0;
  endtask

  // Receiver with random stall bursts.
  always @(negedge clk) begin
    if (!gaps_on) begin
      m_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else if ($urandom_range(0, 11) == 0) begin
      m_tready <= 1'b0;
      sink_stall = $urandom_range(1, 16) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_out_bytes.size() == 0) begin
        flag_mismatch($sformatf("result %0h with nothing expected", m_tdata));
      end else begin
        want = pending_out_bytes.pop_front();
        if (m_tuser !== want.dest)
          flag_mismatch($sformatf("destination %0b, expected %0b", m_tuser, want.dest));
        if (m_tdata !== want.data)
          flag_mismatch($sformatf("byte %0h, expected %0h", m_tdata, want.data));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 3'd0;
    pwdata   = 32'd0;
    parse_st = ST_NORMAL;
    held_cmd = 8'h00;
    sb_opt   = 8'h00;
    sb_first = 1'b0;
    tt_send  = 1'b0;
    bom_cnt  = 2'd0;
    cols_cfg = COLUMNS_RESET;
    rows_cfg = ROWS_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;

    // Directed part at the reset window size.
    for (int i = 0; i < NUM_DIR_ROWS; i++)
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].has_out, dir_rows[i].out_byte);
    s_tvalid <= 1'b0;
    wait_drained();

    // Smallest and largest legal window.
    write_window(REG_COLUMNS, 8'd1);
    write_window(REG_ROWS, 8'd254);
    run_random(120);
    wait_drained();

    // Value that must be clamped.
    write_window(REG_COLUMNS, 8'hFF);
    write_window(REG_ROWS, 8'hFF);
    run_random(100);
    wait_drained();

    write_window(REG_COLUMNS, 8'($urandom_range(1, 254)));
    write_window(REG_ROWS, 8'($urandom_range(1, 254)));
    run_random(100);

    // Last stretch at full rate on both sides.
    gaps_on = 1'b0;
    run_random(100);

    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** telnet_option_negotiator_top: PASSED **");
    end else begin
      $display("** telnet_option_negotiator_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/tonp_pkg.sv
rtl/tonp_parser.sv
rtl/tonp_emitter.sv
rtl/telnet_option_negotiator_top.sv
tb/testbench.sv
